// ----- rtl/ste_pkg.sv -----
// ============================================================================
// ste_pkg
// Shared types and constants of the sorted table engine.
// ============================================================================
package ste_pkg;

    localparam int unsigned DepthDefault    = 256;
    localparam int unsigned KeyBytesDefault = 8;

    localparam int unsigned FuncW  = 2;
    localparam int unsigned KeyW   = 64;
    localparam int unsigned HandleW = 16;
    localparam int unsigned IndexW = 8;
    localparam int unsigned StatusW = 3;
    localparam int unsigned PosW   = 8;
    localparam int unsigned CountW = 9;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 9;

    typedef enum logic [FuncW-1:0] {
        FUNC_SEARCH = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_DUP       = 3'd4
    } t_status;

    localparam logic [CfgIdxW-1:0] CFG_ALLOW_DUP = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_BYTES = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CAPACITY  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_READ_RD,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;       // capture input item
        logic srch_init;   // low to 0, high to count-1, clear found
        logic srch_rd;     // read at mid
        logic srch_step;   // apply compare to low/high
        logic ins_init;    // set pointer to count-1
        logic ins_rd;      // read at pointer
        logic ins_shift;   // copy pointer to pointer+1, step down
        logic ins_place;   // write new item at pointer+1
        logic del_init;    // pointer at found position
        logic del_rd;      // read at pointer+1
        logic del_wr;      // write to pointer, step up
        logic del_fin;     // drop count
        logic idx_rd;      // read at index
        logic finish;      // form result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic  [FuncW-1:0] func;
        logic              srch_done;
        logic              found;
        logic              full;
        logic              allow_dup;
        logic              ins_stop;
        logic              ins_more;
        logic              del_last;
        logic              idx_bad;
    } t_stat;

endpackage

// ----- rtl/ste_datapath.sv -----
// ============================================================================
// ste_datapath
// Table memories, search bounds, shift pointer and result registers.
// ============================================================================
module ste_datapath #(
    parameter int unsigned DEPTH     = ste_pkg::DepthDefault,
    parameter int unsigned KEY_BYTES = ste_pkg::KeyBytesDefault,
    localparam int unsigned AW = $clog2(DEPTH),
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ste_pkg::t_cmd                 i_cmd,
    output ste_pkg::t_stat                o_stat,
    input  logic [ste_pkg::FuncW-1:0]     i_func,
    input  logic [ste_pkg::KeyW-1:0]      i_key,
    input  logic [ste_pkg::HandleW-1:0]   i_handle,
    input  logic [ste_pkg::IndexW-1:0]    i_index,
    input  logic                          i_cfg_we,
    input  logic [ste_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [ste_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic [ste_pkg::StatusW-1:0]   o_status,
    output logic [ste_pkg::PosW-1:0]      o_position,
    output logic [ste_pkg::HandleW-1:0]   o_handle_out,
    output logic [ste_pkg::CountW-1:0]    o_entry_count
);

    localparam int unsigned KW = ste_pkg::KeyW;
    localparam int unsigned HW = ste_pkg::HandleW;

    logic [KW-1:0] key_mem [DEPTH];
    logic [HW-1:0] hnd_mem [DEPTH];

    logic                        r_allow_dup;
    logic [3:0]                  r_key_bytes;
    logic [ste_pkg::CountW-1:0]  r_capacity;
    logic [CW-1:0]               r_count;
    logic [ste_pkg::FuncW-1:0]   r_func;
    logic [KW-1:0]               r_key;
    logic [HW-1:0]               r_handle;
    logic [ste_pkg::IndexW-1:0]  r_index;
    logic                        r_full;
    logic signed [CW:0]          r_lo;
    logic signed [CW:0]          r_hi;
    logic signed [CW:0]          r_ptr;
    logic                        r_found;
    logic [AW-1:0]               r_fpos;
    logic [HW-1:0]               r_hit_hnd;
    logic [KW-1:0]               r_rd_key;
    logic [HW-1:0]               r_rd_hnd;
    logic [HW-1:0]               r_hout;
    logic [ste_pkg::StatusW-1:0] r_status;
    logic [ste_pkg::PosW-1:0]    r_position;

    logic [ste_pkg::StatusW-1:0] n_status;
    logic [ste_pkg::PosW-1:0]    n_position;
    logic [HW-1:0]               n_hout;

    logic signed [CW:0] mid;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic [3:0]         nb;
    logic [KW-1:0]      want;
    logic [KW-1:0]      have;
    logic [CW:0]        cap_sat;
    logic               full_now;
    logic               idx_bad;

    function automatic logic [KW-1:0] cmp_part(input logic [KW-1:0] k, input logic [3:0] n);
        logic [KW-1:0] r;
        r = '0;
        if (n >= 4'd8) begin
            r = k;
        end else if (n != 4'd0) begin
            r = k >> (7'd8 * (7'd8 - {3'd0, n}));
        end
        return r;
    endfunction

    assign nb   = (r_key_bytes > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : r_key_bytes;
    assign want = cmp_part(r_key, nb);
    assign have = cmp_part(r_rd_key, nb);
    assign mid  = (r_lo + r_hi) >>> 1;
    assign cap_sat = ({1'b0, r_capacity} > (CW+1)'(DEPTH)) ? (CW+1)'(DEPTH)
                   : (CW+1)'(r_capacity);
    assign full_now = {1'b0, r_count} >= cap_sat;
    assign idx_bad  = ({1'b0, r_index} >= (ste_pkg::IndexW+1)'(r_count))
                   || ((CW+1)'(r_index) >= (CW+1)'(DEPTH));

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = '0;
        priority if (i_cmd.srch_rd) begin
            rd_addr = mid[AW-1:0];
        end else if (i_cmd.ins_rd) begin
            rd_addr = r_ptr[AW-1:0];
        end else if (i_cmd.del_rd) begin
            rd_addr = AW'(r_ptr + 1);
        end else if (i_cmd.idx_rd) begin
            rd_addr = AW'(r_index);
        end else begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key <= key_mem[rd_addr];
            r_rd_hnd <= hnd_mem[rd_addr];
        end
        if (i_cmd.ins_shift) begin
            key_mem[AW'(r_ptr + 1)] <= r_rd_key;
            hnd_mem[AW'(r_ptr + 1)] <= r_rd_hnd;
        end else if (i_cmd.ins_place) begin
            key_mem[AW'(r_ptr + 1)] <= r_key;
            hnd_mem[AW'(r_ptr + 1)] <= r_handle;
        end else if (i_cmd.del_wr) begin
            key_mem[r_ptr[AW-1:0]] <= r_rd_key;
            hnd_mem[r_ptr[AW-1:0]] <= r_rd_hnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_dup <= 1'b0;
            r_key_bytes <= 4'(KEY_BYTES);
            r_capacity  <= 9'd256;
            r_count     <= '0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ste_pkg::CFG_ALLOW_DUP: r_allow_dup <= i_cfg_data[0];
                    ste_pkg::CFG_KEY_BYTES: r_key_bytes <= i_cfg_data[3:0];
                    ste_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.srch_init) begin
                r_found <= 1'b0;
            end
            if (i_cmd.srch_step && have == want) begin
                r_found <= 1'b1;
            end
            if (i_cmd.ins_place) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.del_fin) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_status   = ste_pkg::ST_OK;
        n_position = '0;
        n_hout     = '0;
        unique case (r_func)
            ste_pkg::FUNC_SEARCH, ste_pkg::FUNC_DELETE: begin
                if (r_found) begin
                    n_position = ste_pkg::PosW'(r_fpos);
                    n_hout     = r_hit_hnd;
                end else begin
                    n_status = ste_pkg::ST_NOT_FOUND;
                end
            end
            ste_pkg::FUNC_INSERT: begin
                if (r_full) begin
                    n_status = ste_pkg::ST_FULL;
                end else if (r_found && !r_allow_dup) begin
                    n_status = ste_pkg::ST_DUP;
                end else begin
                    n_position = ste_pkg::PosW'(r_ptr + 1);
                end
            end
            default: begin
                if (idx_bad) begin
                    n_status = ste_pkg::ST_BAD_INDEX;
                end else begin
                    n_position = r_index;
                    n_hout     = r_rd_hnd;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= i_func;
            r_key    <= i_key;
            r_handle <= i_handle;
            r_index  <= i_index;
            r_full   <= full_now;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= (CW+1)'($signed({1'b0, r_count}) - 1);
        end
        if (i_cmd.srch_step) begin
            if (have == want) begin
                r_fpos    <= mid[AW-1:0];
                r_hit_hnd <= r_rd_hnd;
                r_lo      <= (CW+1)'(r_hi + 1);
            end else if (have < want) begin
                r_lo <= (CW+1)'(mid + 1);
            end else begin
                r_hi <= (CW+1)'(mid - 1);
            end
        end
        if (i_cmd.ins_init) begin
            r_ptr <= (CW+1)'($signed({1'b0, r_count}) - 1);
        end
        if (i_cmd.ins_shift) begin
            r_ptr <= (CW+1)'(r_ptr - 1);
        end
        if (i_cmd.del_init) begin
            r_ptr <= $signed({1'b0, {(CW-AW){1'b0}}, r_fpos});
        end
        if (i_cmd.del_wr) begin
            r_ptr <= (CW+1)'(r_ptr + 1);
        end
        if (i_cmd.finish) begin
            r_status   <= n_status;
            r_position <= n_position;
            r_hout     <= n_hout;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.srch_done = r_hi < r_lo;
    assign o_stat.found     = r_found;
    assign o_stat.full      = full_now;
    assign o_stat.allow_dup = r_allow_dup;
    assign o_stat.ins_stop  = (r_ptr < 0);
    assign o_stat.ins_more  = want <= have;
    assign o_stat.del_last  = (r_ptr + 1) >= $signed({1'b0, r_count});
    assign o_stat.idx_bad   = idx_bad;

    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_handle_out  = r_hout;
    assign o_entry_count = ste_pkg::CountW'(r_count);

endmodule

// ----- rtl/ste_ctrl.sv -----
// ============================================================================
// ste_ctrl
// Sequencer for search, insert shift, delete shift and index read.
// ============================================================================
module ste_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ste_pkg::t_stat  i_stat,
    output ste_pkg::t_cmd   o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    ste_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ste_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        o_busy  = (r_state != ste_pkg::S_IDLE);
        unique case (r_state)
            ste_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = ste_pkg::S_DISPATCH;
                end
            end
            ste_pkg::S_DISPATCH: begin
                if (i_stat.func == ste_pkg::FUNC_READ) begin
                    o_cmd.idx_rd = 1'b1;
                    n_state = ste_pkg::S_READ_RD;
                end else if (i_stat.func == ste_pkg::FUNC_INSERT && i_stat.full) begin
                    n_state = ste_pkg::S_DONE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state = ste_pkg::S_SRCH_RD;
                end
            end
            ste_pkg::S_SRCH_RD: begin
                if (i_stat.srch_done) begin
                    if (i_stat.func == ste_pkg::FUNC_INSERT
                            && !(i_stat.found && !i_stat.allow_dup)) begin
                        o_cmd.ins_init = 1'b1;
                        n_state = ste_pkg::S_INS_RD;
                    end else if (i_stat.func == ste_pkg::FUNC_DELETE && i_stat.found) begin
                        o_cmd.del_init = 1'b1;
                        n_state = ste_pkg::S_DEL_RD;
                    end else begin
                        n_state = ste_pkg::S_DONE;
                    end
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = ste_pkg::S_SRCH_CMP;
                end
            end
            ste_pkg::S_SRCH_CMP: begin
                o_cmd.srch_step = 1'b1;
                n_state = ste_pkg::S_SRCH_RD;
            end
            ste_pkg::S_INS_RD: begin
                if (i_stat.ins_stop) begin
                    o_cmd.ins_place = 1'b1;
                    n_state = ste_pkg::S_DONE;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state = ste_pkg::S_INS_CMP;
                end
            end
            ste_pkg::S_INS_CMP: begin
                if (i_stat.ins_more) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state = ste_pkg::S_INS_RD;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state = ste_pkg::S_DONE;
                end
            end
            ste_pkg::S_DEL_RD: begin
                if (i_stat.del_last) begin
                    o_cmd.del_fin = 1'b1;
                    n_state = ste_pkg::S_DONE;
                end else begin
                    o_cmd.del_rd = 1'b1;
                    n_state = ste_pkg::S_DEL_WR;
                end
            end
            ste_pkg::S_DEL_WR: begin
                o_cmd.del_wr = 1'b1;
                n_state = ste_pkg::S_DEL_RD;
            end
            ste_pkg::S_READ_RD: begin
                n_state = ste_pkg::S_DONE;
            end
            ste_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                o_done = 1'b1;
                n_state = ste_pkg::S_IDLE;
            end
            default: n_state = ste_pkg::S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_latch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ste_pkg::S_IDLE) |-> !o_cmd.latch)
        else $error("latch while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == ste_pkg::S_IDLE))
        else $error("done not followed by idle");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.ins_shift, o_cmd.ins_place, o_cmd.del_wr}))
        else $error("two table writes");
`endif

endmodule

// ----- rtl/sorted_table_engine.sv -----
// ============================================================================
// sorted_table_engine
// Sorted key/handle table with search, insert, delete and index read.
// ============================================================================
//  channel   handshake             payload
//  input     i_start & !o_busy     i_func i_key i_handle i_index
//  config    i_cfg_valid&o_cfg_rdy i_cfg_index i_cfg_data
//  result    o_done (one cycle)    o_status o_position o_handle_out o_entry_count
// Search makes n table probes, n <= log2(count)+1, one read each; insert then shifts
// entries up one at a time, delete moves them down one at a time, read makes one
// table read, and a full insert skips the search. One table read port sets this
// pace. Config is taken only while idle. Reset clears count and configuration
// registers; the result cannot be stalled.
module sorted_table_engine #(
    parameter int unsigned DEPTH     = ste_pkg::DepthDefault,
    parameter int unsigned KEY_BYTES = ste_pkg::KeyBytesDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [ste_pkg::FuncW-1:0]     i_func,
    input  logic [ste_pkg::KeyW-1:0]      i_key,
    input  logic [ste_pkg::HandleW-1:0]   i_handle,
    input  logic [ste_pkg::IndexW-1:0]    i_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ste_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [ste_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic                          o_done,
    output logic [ste_pkg::StatusW-1:0]   o_status,
    output logic [ste_pkg::PosW-1:0]      o_position,
    output logic [ste_pkg::HandleW-1:0]   o_handle_out,
    output logic [ste_pkg::CountW-1:0]    o_entry_count
);

    ste_pkg::t_cmd  cmd;
    ste_pkg::t_stat stat;
    logic           r_done;
    logic           ctl_done;

    assign o_cfg_ready = !o_busy;

    ste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (o_busy),
        .o_done     (ctl_done)
    );

    ste_datapath #(.DEPTH(DEPTH), .KEY_BYTES(KEY_BYTES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_handle      (i_handle),
        .i_index       (i_index),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_idx     (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_handle_out  (o_handle_out),
        .o_entry_count (o_entry_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ctl_done;
        end
    end

    assign o_done = r_done;

endmodule

// ----- test/tb_sorted_table_engine.sv -----
// ============================================================================
// tb_sorted_table_engine
// Self-checking testbench of the sorted table engine: a scoreboard keeps its
// own copy of the table and configuration, predicts each result and compares
// it field by field; directed items cover the corners, random phases cover
// several register settings.
// ============================================================================
`timescale 1ns / 1ps

module tb_sorted_table_engine;

    localparam int unsigned TblDepth   = 256;
    localparam int unsigned QuietLimit = 8000;
    localparam int unsigned PerPhase   = 160;

    typedef struct {
        ste_pkg::t_status            status;
        logic [ste_pkg::PosW-1:0]    position;
        logic [ste_pkg::HandleW-1:0] handle;
        logic [ste_pkg::CountW-1:0]  count;
    } t_table_result;

    class t_table_scoreboard;
        logic [ste_pkg::KeyW-1:0]    keys[TblDepth];
        logic [ste_pkg::HandleW-1:0] handles[TblDepth];
        int unsigned        count;
        bit                 allow_dup;
        int unsigned        key_bytes;
        int unsigned        capacity;
        t_table_result      expected[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        per_status[5];

        function new();
            count     = 0;
            allow_dup = 0;
            key_bytes = ste_pkg::KeyBytesDefault;
            capacity  = 256;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(logic [ste_pkg::CfgIdxW-1:0] idx,
                                logic [ste_pkg::CfgDataW-1:0] data);
            case (idx)
                ste_pkg::CFG_ALLOW_DUP: allow_dup = data[0];
                ste_pkg::CFG_KEY_BYTES: key_bytes = data[3:0];
                ste_pkg::CFG_CAPACITY:  capacity  = data;
                default: ;
            endcase
        endfunction

        function logic [ste_pkg::KeyW-1:0] key_part(logic [ste_pkg::KeyW-1:0] k);
            int unsigned n;
            n = (key_bytes > ste_pkg::KeyBytesDefault) ? ste_pkg::KeyBytesDefault
                                                       : key_bytes;
            if (n == 0) return '0;
            if (n == 8) return k;
            return k >> (8 * (8 - n));
        endfunction

        function int locate(logic [ste_pkg::KeyW-1:0] k);
            int lo;
            int hi;
            int mid;
            logic [ste_pkg::KeyW-1:0] want;
            logic [ste_pkg::KeyW-1:0] have;
            lo   = 0;
            hi   = int'(count) - 1;
            want = key_part(k);
            while (hi >= lo) begin
                mid  = (lo + hi) / 2;
                have = key_part(keys[mid]);
                if (have == want) return mid;
                if (have < want) lo = mid + 1;
                else hi = mid - 1;
            end
            return -1;
        endfunction

        function void note_item(ste_pkg::t_func f, logic [ste_pkg::KeyW-1:0] k,
                                logic [ste_pkg::HandleW-1:0] h,
                                logic [ste_pkg::IndexW-1:0] idx);
            t_table_result r;
            int p;
            int i;
            int unsigned lim;
            r.status   = ste_pkg::ST_OK;
            r.position = '0;
            r.handle   = '0;
            case (f)
                ste_pkg::FUNC_SEARCH: begin
                    p = locate(k);
                    if (p < 0) r.status = ste_pkg::ST_NOT_FOUND;
                    else begin
                        r.position = ste_pkg::PosW'(p);
                        r.handle   = handles[p];
                    end
                end
                ste_pkg::FUNC_INSERT: begin
                    lim = (capacity > TblDepth) ? TblDepth : capacity;
                    if (count >= lim) r.status = ste_pkg::ST_FULL;
                    else if (locate(k) >= 0 && !allow_dup) r.status = ste_pkg::ST_DUP;
                    else begin
                        i = int'(count) - 1;
                        while (i >= 0 && key_part(k) <= key_part(keys[i])) begin
                            keys[i+1]    = keys[i];
                            handles[i+1] = handles[i];
                            i--;
                        end
                        keys[i+1]    = k;
                        handles[i+1] = h;
                        count++;
                        r.position = ste_pkg::PosW'(i + 1);
                    end
                end
                ste_pkg::FUNC_DELETE: begin
                    p = locate(k);
                    if (p < 0) r.status = ste_pkg::ST_NOT_FOUND;
                    else begin
                        r.position = ste_pkg::PosW'(p);
                        r.handle   = handles[p];
                        for (i = p; i + 1 < int'(count); i++) begin
                            keys[i]    = keys[i+1];
                            handles[i] = handles[i+1];
                        end
                        count--;
                    end
                end
                default: begin
                    if (idx >= count) r.status = ste_pkg::ST_BAD_INDEX;
                    else begin
                        r.position = idx;
                        r.handle   = handles[idx];
                    end
                end
            endcase
            r.count = ste_pkg::CountW'(count);
            expected.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [ste_pkg::StatusW-1:0] st, logic [ste_pkg::PosW-1:0] pos,
                          logic [ste_pkg::HandleW-1:0] h,
                          logic [ste_pkg::CountW-1:0] cnt);
            t_table_result e;
            if (expected.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = expected.pop_front();
                checked++;
                if (e.status < 5) per_status[e.status]++;
                if (st !== e.status)
                    report($sformatf("status %0d, want %0d", st, e.status));
                if (pos !== e.position)
                    report($sformatf("position %0d, want %0d", pos, e.position));
                if (h !== e.handle)
                    report($sformatf("handle %h, want %h", h, e.handle));
                if (cnt !== e.count)
                    report($sformatf("entry count %0d, want %0d", cnt, e.count));
            end
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic [ste_pkg::FuncW-1:0]     i_func;
    logic [ste_pkg::KeyW-1:0]      i_key;
    logic [ste_pkg::HandleW-1:0]   i_handle;
    logic [ste_pkg::IndexW-1:0]    i_index;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [ste_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [ste_pkg::CfgDataW-1:0]  i_cfg_data;
    logic                          o_done;
    logic [ste_pkg::StatusW-1:0]   o_status;
    logic [ste_pkg::PosW-1:0]      o_position;
    logic [ste_pkg::HandleW-1:0]   o_handle_out;
    logic [ste_pkg::CountW-1:0]    o_entry_count;

    t_table_scoreboard         sb;
    logic [ste_pkg::KeyW-1:0]  key_pool[48];
    bit                        calm;
    int unsigned               quiet;
    int unsigned               sent;

    sorted_table_engine u_top (.*);

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_position, o_handle_out, o_entry_count);
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QuietLimit) begin
            $display("watchdog expired at %0t", $time);
            $display("simulation failed");
            $finish;
        end
    end

    task send_item(ste_pkg::t_func f, logic [ste_pkg::KeyW-1:0] k,
                   logic [ste_pkg::HandleW-1:0] h, logic [ste_pkg::IndexW-1:0] idx);
        int unsigned gap;
        if (!calm && $urandom_range(0, 99) < 22) begin
            i_start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        i_func   <= f;
        i_key    <= k;
        i_handle <= h;
        i_index  <= idx;
        i_start  <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(f, k, h, idx);
        sent++;
    endtask

    task drain();
        i_start <= 1'b0;
        while (sb.expected.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // leaves the write valid raised; the caller drops it after the last write
    task write_reg(logic [ste_pkg::CfgIdxW-1:0] idx, logic [ste_pkg::CfgDataW-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task set_regs(bit dup, logic [3:0] kb, logic [ste_pkg::CfgDataW-1:0] cap);
        drain();
        write_reg(ste_pkg::CFG_ALLOW_DUP, ste_pkg::CfgDataW'(dup));
        write_reg(ste_pkg::CFG_KEY_BYTES, ste_pkg::CfgDataW'(kb));
        write_reg(ste_pkg::CFG_CAPACITY, cap);
        i_cfg_valid <= 1'b0;
    endtask

    function logic [ste_pkg::KeyW-1:0] fresh_key();
        logic [ste_pkg::KeyW-1:0] k;
        for (int b = 0; b < 8; b++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: k[b*8 +: 8] = 8'($urandom_range(0, 2));
                5, 6:          k[b*8 +: 8] = 8'hFF;
                default:       k[b*8 +: 8] = 8'($urandom);
            endcase
        end
        return k;
    endfunction

    task random_phase(int unsigned n);
        int unsigned sel;
        ste_pkg::t_func f;
        logic [ste_pkg::KeyW-1:0] k;
        logic [ste_pkg::IndexW-1:0] idx;
        for (int i = 0; i < 48; i++) key_pool[i] = fresh_key();
        for (int unsigned i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 38) f = ste_pkg::FUNC_INSERT;
            else if (sel < 62) f = ste_pkg::FUNC_SEARCH;
            else if (sel < 85) f = ste_pkg::FUNC_DELETE;
            else f = ste_pkg::FUNC_READ;
            if ($urandom_range(0, 3) == 0) k = {$urandom, $urandom};
            else k = key_pool[$urandom_range(0, 47)];
            if ($urandom_range(0, 4) == 0) idx = ste_pkg::IndexW'($urandom);
            else idx = (sb.count + 2 > 255) ? 8'd255
                     : ste_pkg::IndexW'($urandom_range(0, sb.count + 1));
            send_item(f, k, ste_pkg::HandleW'($urandom), idx);
        end
    endtask

    initial begin
        sb          = new();
        calm        = 1'b0;
        quiet       = 0;
        sent        = 0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_func      = ste_pkg::FUNC_SEARCH;
        i_key       = '0;
        i_handle    = '0;
        i_index     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ste_pkg::CFG_ALLOW_DUP;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then extremes of every field
        send_item(ste_pkg::FUNC_SEARCH, 64'h0, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_DELETE, '1, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_READ, 64'h0, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_INSERT, 64'h0, 16'h0000, 8'h0);
        send_item(ste_pkg::FUNC_INSERT, '1, 16'hFFFF, 8'hFF);
        send_item(ste_pkg::FUNC_INSERT, 64'h8000_0000_0000_0001, 16'h5A5A, 8'h0);
        send_item(ste_pkg::FUNC_INSERT, '1, 16'h1234, 8'h0);
        send_item(ste_pkg::FUNC_SEARCH, '1, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_READ, 64'h0, 16'h0, 8'd2);
        send_item(ste_pkg::FUNC_READ, 64'h0, 16'h0, 8'd3);
        send_item(ste_pkg::FUNC_READ, 64'h0, 16'h0, 8'hFF);
        send_item(ste_pkg::FUNC_DELETE, 64'h0, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_DELETE, 64'h0, 16'h0, 8'h0);

        // duplicates allowed, one key byte, capacity two; then no duplicates, no key bytes, capacity zero
        set_regs(1'b1, 4'd1, 9'd2);
        send_item(ste_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000, 16'hAAAA, 8'h0);
        send_item(ste_pkg::FUNC_INSERT, 64'h80FF_0000_0000_0000, 16'h5555, 8'h0);
        send_item(ste_pkg::FUNC_SEARCH, 64'h8012_3456_789A_BCDE, 16'h0, 8'h0);
        set_regs(1'b0, 4'd0, 9'd0);
        send_item(ste_pkg::FUNC_INSERT, 64'h1, 16'h1, 8'h0);
        send_item(ste_pkg::FUNC_SEARCH, 64'h1, 16'h0, 8'h0);
        send_item(ste_pkg::FUNC_DELETE, 64'h2, 16'h0, 8'h0);
        set_regs(1'b1, 4'd15, 9'd511);
        send_item(ste_pkg::FUNC_INSERT, 64'h0, 16'hC3C3, 8'h0);
        send_item(ste_pkg::FUNC_DELETE, '1, 16'h0, 8'h0);

        set_regs(1'b0, 4'd8, 9'd256);
        random_phase(PerPhase);
        set_regs(1'b1, 4'd2, 9'd16);
        random_phase(PerPhase);
        calm = 1'b1;
        set_regs(1'b0, 4'd1, 9'd300);
        random_phase(PerPhase);
        calm = 1'b0;
        set_regs(1'b1, 4'd8, 9'd1);
        random_phase(PerPhase);
        set_regs(1'b1, 4'd0, 9'd8);
        random_phase(PerPhase);
        set_regs(1'b0, 4'd12, 9'd511);
        random_phase(PerPhase);
        set_regs(1'b1, 4'd4, 9'd3);
        random_phase(PerPhase);
        set_regs(1'b0, 4'd3, 9'd64);
        random_phase(PerPhase);

        drain();
        repeat (20) @(posedge i_clk);
        $display("items sent %0d, results checked %0d, table left with %0d entries",
                 sent, sb.checked, sb.count);
        $display("ok %0d full %0d not found %0d bad index %0d duplicate %0d",
                 sb.per_status[ste_pkg::ST_OK], sb.per_status[ste_pkg::ST_FULL],
                 sb.per_status[ste_pkg::ST_NOT_FOUND],
                 sb.per_status[ste_pkg::ST_BAD_INDEX], sb.per_status[ste_pkg::ST_DUP]);
        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
